>>> rtl/frf_pkg.sv
// Shared types and constants for the FTP reply framer.
// Byte classes, framing states, status codes and default queue depths.
// No dependencies.
package frf_pkg;

  localparam logic [7:0] ChrDigit0 = 8'h30;
  localparam logic [7:0] ChrDigit9 = 8'h39;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrMinus  = 8'h2D;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrLf     = 8'h0A;

  localparam int unsigned MidDepthDefault = 2;
  localparam int unsigned OutDepthDefault = 2;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_SPACE = 3'd1,
    CLS_MINUS = 3'd2,
    CLS_CR    = 3'd3,
    CLS_LF    = 3'd4,
    CLS_OTHER = 3'd5
  } cls_e;

  typedef enum logic [3:0] {
    ST_START    = 4'd0,
    ST_CODE2    = 4'd1,
    ST_CODE3    = 4'd2,
    ST_SEP      = 4'd3,
    ST_BODY_CR  = 4'd4,
    ST_BODY_LF  = 4'd5,
    ST_LINE     = 4'd6,
    ST_CLOSE2   = 4'd7,
    ST_CLOSE3   = 4'd8,
    ST_CLOSE_SP = 4'd9,
    ST_LAST_CR  = 4'd10,
    ST_LAST_LF  = 4'd11,
    ST_ERR      = 4'd13,
    ST_DONE     = 4'd14
  } state_e;

  typedef enum logic [1:0] {
    STATUS_BUSY = 2'd0,
    STATUS_DONE = 2'd1,
    STATUS_ERR  = 2'd2
  } status_e;

  typedef struct packed {
    status_e status;
    logic    line_end;
  } result_t;

endpackage

>>> rtl/frf_fifo.sv
// Small first-in first-out queue built from flip-flops.
// Generic in width and depth; no package dependency.
module frf_fifo #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("fifo count beyond depth");

endmodule

>>> rtl/frf_front.sv
// Front end of the reply framer: accepts received bytes and sorts each
// into a character class for the framing queue. Depends on frf_pkg.
module frf_front (
  input  logic          push_i,
  input  logic [7:0]    rx_byte_i,
  output logic          full_o,
  input  logic          mid_full_i,
  output logic          mid_push_o,
  output frf_pkg::cls_e mid_cls_o
);
  import frf_pkg::*;

  assign full_o     = mid_full_i;
  assign mid_push_o = push_i;

  always_comb begin
    if (rx_byte_i inside {[ChrDigit0:ChrDigit9]}) begin
      mid_cls_o = CLS_DIGIT;
    end else begin
      case (rx_byte_i)
        ChrSpace: mid_cls_o = CLS_SPACE;
        ChrMinus: mid_cls_o = CLS_MINUS;
        ChrCr:    mid_cls_o = CLS_CR;
        ChrLf:    mid_cls_o = CLS_LF;
        default:  mid_cls_o = CLS_OTHER;
      endcase
    end
  end

endmodule

>>> rtl/frf_back.sv
// Back end of the reply framer: steps the framing state machine on each
// queued byte class and emits one status beat per byte. Depends on frf_pkg.
module frf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mid_empty_i,
  input  frf_pkg::cls_e   mid_cls_i,
  output logic            mid_pop_o,
  input  logic            out_full_i,
  output logic            out_push_o,
  output frf_pkg::result_t out_result_o
);
  import frf_pkg::*;

  state_e state_q, state_d, tgt_st;
  logic   prev_cr_q, prev_cr_d;
  logic   step;

  assign step       = !mid_empty_i && !out_full_i;
  assign mid_pop_o  = step;
  assign out_push_o = step;

  // Transition target, including the error and complete markers.
  always_comb begin
    tgt_st = ST_ERR;
    case (state_q)
      ST_CODE2:    tgt_st = (mid_cls_i == CLS_DIGIT) ? ST_CODE3 : ST_ERR;
      ST_CODE3:    tgt_st = (mid_cls_i == CLS_DIGIT) ? ST_SEP : ST_ERR;
      ST_SEP: begin
        case (mid_cls_i)
          CLS_SPACE: tgt_st = ST_LAST_CR;
          CLS_MINUS: tgt_st = ST_BODY_CR;
          default:   tgt_st = ST_ERR;
        endcase
      end
      ST_BODY_CR:  tgt_st = (mid_cls_i == CLS_CR) ? ST_BODY_LF : ST_BODY_CR;
      ST_BODY_LF:  tgt_st = (mid_cls_i == CLS_LF) ? ST_LINE : ST_BODY_CR;
      ST_LINE: begin
        case (mid_cls_i)
          CLS_DIGIT: tgt_st = ST_CLOSE2;
          CLS_SPACE: tgt_st = ST_BODY_CR;
          default:   tgt_st = ST_ERR;
        endcase
      end
      ST_CLOSE2:   tgt_st = (mid_cls_i == CLS_DIGIT) ? ST_CLOSE3 : ST_ERR;
      ST_CLOSE3:   tgt_st = (mid_cls_i == CLS_DIGIT) ? ST_CLOSE_SP : ST_ERR;
      ST_CLOSE_SP: tgt_st = (mid_cls_i == CLS_SPACE) ? ST_LAST_CR : ST_ERR;
      ST_LAST_CR:  tgt_st = (mid_cls_i == CLS_CR) ? ST_LAST_LF : ST_LAST_CR;
      ST_LAST_LF:  tgt_st = (mid_cls_i == CLS_LF) ? ST_DONE : ST_LAST_CR;
      default:     tgt_st = (mid_cls_i == CLS_DIGIT) ? ST_CODE2 : ST_ERR;
    endcase
  end

  // Next state: a finished or failed reply returns to the start state.
  always_comb begin
    state_d   = state_q;
    prev_cr_d = prev_cr_q;
    if (step) begin
      prev_cr_d = (mid_cls_i == CLS_CR);
      if (tgt_st == ST_ERR || tgt_st == ST_DONE) begin
        state_d = ST_START;
      end else begin
        state_d = tgt_st;
      end
    end
  end

  // Outputs of the current step.
  always_comb begin
    case (tgt_st)
      ST_ERR:  out_result_o.status = STATUS_ERR;
      ST_DONE: out_result_o.status = STATUS_DONE;
      default: out_result_o.status = STATUS_BUSY;
    endcase
    out_result_o.line_end = (mid_cls_i == CLS_LF) && prev_cr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_START;
      prev_cr_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      prev_cr_q <= prev_cr_d;
    end
  end

  a_end_to_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && out_result_o.status != STATUS_BUSY |=> state_q == ST_START)
    else $error("framer did not return to start after a finished reply");

  a_line_end_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && out_result_o.line_end |-> $past(prev_cr_d))
    else $error("line end flagged without a preceding CR");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(state_q) && $stable(prev_cr_q))
    else $error("framer state moved without a byte");

endmodule

>>> rtl/ftp_reply_framer.sv
// Top level of the FTP reply framer.
// Instantiates frf_front, two frf_fifo queues and frf_back; uses frf_pkg.
//
// Usage:
//   Input channel: present one reply byte on rx_byte_i and raise push; the
//   beat is taken at a rising edge where full is low. Result channel: while
//   empty is low, frame_status_o and line_end_o show the oldest status beat;
//   raise pop to take it. Every byte yields exactly one status beat, in order.
//   frame_status_o is 0 while a reply is in progress, 1 on the byte that
//   completes it and 2 on a format error; after 1 or 2 the framer starts over
//   on the next byte. line_end_o marks an LF whose preceding byte was CR.
//   Each byte is held in the byte queue, and its status beat in the status
//   queue. Throughput: one byte per clock while pop stays high; the framing
//   machine takes one state step per byte, and both queues push and pop in
//   the same cycle.
//   Reset (rst_ni low, asynchronous) empties both queues, puts the framer in
//   the wait-for-first-digit state and clears the CR memory.
//   When the receiver stalls, the output queue fills, the framer stops, the
//   byte queue fills and full rises; no beat is lost or repeated.
module ftp_reply_framer #(
  parameter int unsigned MidDepth = frf_pkg::MidDepthDefault,
  parameter int unsigned OutDepth = frf_pkg::OutDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] frame_status_o,
  output logic       line_end_o
);
  import frf_pkg::*;

  // Byte classes travel from the front end to the framer through this queue.
  logic    mid_push, mid_full, mid_pop, mid_empty;
  cls_e    front_cls, mid_cls;
  logic [$bits(cls_e)-1:0] mid_rd;

  // Status beats wait here for the receiver.
  logic    out_push, out_full;
  result_t out_wr, out_rd;
  logic [$bits(result_t)-1:0] out_rd_bits;

  frf_front u_front (
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_cls_o  (front_cls)
  );

  frf_fifo #(
    .Width ($bits(cls_e)),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (front_cls),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rd),
    .empty_o (mid_empty)
  );

  assign mid_cls = cls_e'(mid_rd);

  frf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mid_empty_i  (mid_empty),
    .mid_cls_i    (mid_cls),
    .mid_pop_o    (mid_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_result_o (out_wr)
  );

  frf_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wr),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rd_bits),
    .empty_o (empty)
  );

  assign out_rd         = result_t'(out_rd_bits);
  assign frame_status_o = out_rd.status;
  assign line_end_o     = out_rd.line_end;

endmodule

>>> bench/ftp_reply_framer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ftp_reply_framer: byte-serial FTP reply framing.
// Holds its own framing predictor in a small scoreboard class; uses frf_pkg.
module ftp_reply_framer_tb;
  import frf_pkg::*;

  // The status stream is checked against this scoreboard. It follows the byte
  // stream with its own copy of the framing state and of the CR memory, and
  // queues one expected status beat for every byte that the block takes.
  class reply_scoreboard;
    state_e    framer_state;
    bit        last_was_cr;
    result_t   status_q[$];
    int unsigned mismatches;
    int unsigned beats_seen;

    function new();
      framer_state = ST_START;
      last_was_cr  = 1'b0;
      mismatches   = 0;
      beats_seen   = 0;
    endfunction

    // Steps the framing machine by one accepted byte and queues its status.
    function void note_byte(logic [7:0] b);
      cls_e    cls;
      state_e  nxt;
      result_t r;
      if (b >= ChrDigit0 && b <= ChrDigit9) cls = CLS_DIGIT;
      else if (b == ChrSpace) cls = CLS_SPACE;
      else if (b == ChrMinus) cls = CLS_MINUS;
      else if (b == ChrCr) cls = CLS_CR;
      else if (b == ChrLf) cls = CLS_LF;
      else cls = CLS_OTHER;

      case (framer_state)
        ST_CODE2: begin
          nxt = (cls == CLS_DIGIT) ? ST_CODE3 : ST_ERR;
        end
        ST_CODE3: begin
          nxt = (cls == CLS_DIGIT) ? ST_SEP : ST_ERR;
        end
        ST_SEP: begin
          if (cls == CLS_SPACE) nxt = ST_LAST_CR;
          else if (cls == CLS_MINUS) nxt = ST_BODY_CR;
          else nxt = ST_ERR;
        end
        ST_BODY_CR: begin
          nxt = (cls == CLS_CR) ? ST_BODY_LF : ST_BODY_CR;
        end
        ST_BODY_LF: begin
          nxt = (cls == CLS_LF) ? ST_LINE : ST_BODY_CR;
        end
        ST_LINE: begin
          if (cls == CLS_DIGIT) nxt = ST_CLOSE2;
          else if (cls == CLS_SPACE) nxt = ST_BODY_CR;
          else nxt = ST_ERR;
        end
        ST_CLOSE2: begin
          nxt = (cls == CLS_DIGIT) ? ST_CLOSE3 : ST_ERR;
        end
        ST_CLOSE3: begin
          nxt = (cls == CLS_DIGIT) ? ST_CLOSE_SP : ST_ERR;
        end
        ST_CLOSE_SP: begin
          nxt = (cls == CLS_SPACE) ? ST_LAST_CR : ST_ERR;
        end
        ST_LAST_CR: begin
          nxt = (cls == CLS_CR) ? ST_LAST_LF : ST_LAST_CR;
        end
        ST_LAST_LF: begin
          nxt = (cls == CLS_LF) ? ST_DONE : ST_LAST_CR;
        end
        default: begin
          nxt = (cls == CLS_DIGIT) ? ST_CODE2 : ST_ERR;
        end
      endcase

      // The line-end flag looks only at the raw byte before, across replies.
      r.line_end  = (cls == CLS_LF) && last_was_cr;
      last_was_cr = (cls == CLS_CR);

      if (nxt == ST_ERR) begin
        r.status     = STATUS_ERR;
        framer_state = ST_START;
      end else if (nxt == ST_DONE) begin
        r.status     = STATUS_DONE;
        framer_state = ST_START;
      end else begin
        r.status     = STATUS_BUSY;
        framer_state = nxt;
      end
      status_q.push_back(r);
    endfunction

    // Compares one accepted status beat with the oldest expectation.
    function void check_beat(logic [1:0] status, logic line_end);
      result_t want;
      beats_seen++;
      if (status_q.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected status beat %0d: status=%0d line_end=%0b",
                   $time, beats_seen, status, line_end);
        mismatches++;
        return;
      end
      want = status_q.pop_front();
      if (status !== want.status || line_end !== want.line_end) begin
        if (mismatches < 10)
          $display("[%0t] beat %0d: expected status=%0d line_end=%0b, got status=%0d line_end=%0b",
                   $time, beats_seen, want.status, want.line_end, status, line_end);
        mismatches++;
      end
    endfunction
  endclass

  localparam int unsigned ByteTarget   = 1550;
  localparam int unsigned QuietFrom    = 1300;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned DrainCycles  = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] rx_byte_i;
  logic       empty;
  logic       pop;
  logic [1:0] frame_status_o;
  logic       line_end_o;

  reply_scoreboard sb = new();

  // Idle bursts on both sides are switched off for the tail of the run so
  // that the block also sees long stretches at full rate.
  bit          idle_on = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  reply_q[$];

  ftp_reply_framer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte_i),
    .empty          (empty),
    .pop            (pop),
    .frame_status_o (frame_status_o),
    .line_end_o     (line_end_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Reply text is mostly printable, with the odd arbitrary byte. An arbitrary
  // CR or LF inside the text can knock the line structure off, which is fine:
  // the predictor follows whatever the stream does.
  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] code_digit();
    return ChrDigit0 + 8'($urandom_range(0, 9));
  endfunction

  // Appends up to six text bytes and the CRLF that closes the line.
  task automatic add_text_line();
    repeat ($urandom_range(0, 6)) reply_q.push_back(text_byte());
    reply_q.push_back(ChrCr);
    reply_q.push_back(ChrLf);
  endtask

  // Builds one reply into reply_q. Most replies are well formed, single or
  // multi-line; some get one byte overwritten and a few are pure noise, so
  // error exits are taken from every state that has one.
  task automatic build_reply();
    int unsigned pick;
    reply_q.delete();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 8)) reply_q.push_back(8'($urandom));
      return;
    end
    repeat (3) reply_q.push_back(code_digit());
    if ($urandom_range(0, 1) == 0) begin
      reply_q.push_back(ChrSpace);
    end else begin
      // Opening line, continuation lines led by a space, then the closing
      // code line. The closing code is random and need not match.
      reply_q.push_back(ChrMinus);
      add_text_line();
      repeat ($urandom_range(0, 3)) begin
        reply_q.push_back(ChrSpace);
        add_text_line();
      end
      repeat (3) reply_q.push_back(code_digit());
      reply_q.push_back(ChrSpace);
    end
    add_text_line();
    if (pick <= 3)
      reply_q[$urandom_range(0, reply_q.size() - 1)] = 8'($urandom);
  endtask

  // Offers one byte, after an optional idle burst, and returns at the edge
  // that takes it. push stays high when the next call follows at once.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    push      = 1'b1;
    rx_byte_i = b;
    do @(posedge clk_i); while (full);
    sb.note_byte(b);
    bytes_sent++;
    if (bytes_sent >= QuietFrom) idle_on = 1'b0;
  endtask

  // Receiver side: pop is high except during random stalls.
  initial begin : receiver
    int unsigned hold;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pop  = 1'b0;
        hold = $urandom_range(0, 6);
      end else begin
        pop = 1'b1;
      end
    end
  end

  // Every status beat taken by the receiver goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_beat(frame_status_o, line_end_o);
  end

  // Watchdog: too many cycles in a row without any beat moving ends the run.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] opening_q[$];
    rst_ni    = 1'b0;
    push      = 1'b0;
    rx_byte_i = 8'h00;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening: extreme bytes as errors at the start, a digit then a
    // letter, a complete single-line reply, and a multi-line reply with a
    // repeated CR, a space continuation line and a bad closing code line.
    opening_q = '{8'hFF, 8'h00, "0", "a",
                  "1", "2", "3", ChrSpace, ChrCr, ChrLf,
                  "9", "9", "9", ChrMinus, ChrCr, ChrCr, ChrLf, ChrCr, ChrLf,
                  ChrSpace, ChrCr, ChrLf, "0", ChrMinus};
    foreach (opening_q[i]) send_byte(opening_q[i]);

    while (bytes_sent < ByteTarget) begin
      build_reply();
      foreach (reply_q[i]) send_byte(reply_q[i]);
    end
    @(negedge clk_i);
    push = 1'b0;

    // Let every expected beat come out, then watch for anything extra.
    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.status_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
